### rtl/tbw_pkg.sv
// ============================================================================
// tbw_pkg: shared types and constants of the barycentric weight block
// Payload structs, derived datapath widths and the triangle vertex tables.
// ============================================================================
package tbw_pkg;

  // Field widths.
  localparam int COORD_W     = 16;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 14;

  // Derived datapath widths.
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int MAG_W       = 2 * DIFF_W;
  localparam int HALF_W      = MAG_W / 2;
  localparam int AREA_W      = 2 * MAG_W;
  localparam int QUO_W       = 2 * WEIGHT_W;
  localparam int RATIO_SHIFT = 2 * WEIGHT_FRAC;
  localparam int GUARD_W     = QUO_W - RATIO_SHIFT;
  localparam int ROOT_REM_W  = WEIGHT_W + 1;

  // Pipeline depths.
  localparam int FRONT_STAGES = 7;
  localparam int RATIO_LAT    = 1 + QUO_W + WEIGHT_W;

  // Points and triangles.
  localparam int NUM_PT   = 4;
  localparam int NUM_AXIS = 3;
  localparam int NUM_TRI  = 4;
  localparam int NUM_WT   = 3;

  localparam int PT_A = 0;
  localparam int PT_B = 1;
  localparam int PT_C = 2;
  localparam int PT_P = 3;

  localparam int TRI_ABC = 0;
  localparam int TRI_CAP = 1;
  localparam int TRI_ABP = 2;
  localparam int TRI_BCP = 3;

  // Each triangle is (origin, first, second); edges run from the origin.
  localparam int TRI_ORG [NUM_TRI] = '{PT_A, PT_C, PT_A, PT_B};
  localparam int TRI_P1  [NUM_TRI] = '{PT_B, PT_A, PT_B, PT_C};
  localparam int TRI_P2  [NUM_TRI] = '{PT_C, PT_P, PT_P, PT_P};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [WEIGHT_W-1:0]       weight_t;
  typedef logic [AREA_W-1:0]         area_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    coord_t p_x;
    coord_t p_y;
    coord_t p_z;
  } tbw_in_t;

  typedef struct packed {
    weight_t weight_u;
    weight_t weight_v;
    weight_t weight_w;
    logic    degenerate;
  } tbw_out_t;

  typedef struct packed {
    logic valid;
    logic degenerate;
  } tbw_ctl_t;

endpackage

### rtl/tbw_ratio.sv
// ============================================================================
// tbw_ratio: pipelined square root of an area ratio
// Computes floor(sqrt(sx * 2^28 / sabc)) as a saturating Q2.14 weight, with a
// one-bit-per-stage restoring divider followed by a restoring square root.
// ============================================================================
module tbw_ratio
  import tbw_pkg::*;
(
  input  logic    clk,
  input  area_t   sx,
  input  area_t   sabc,
  output weight_t weight
);

  // Divider stage registers.
  area_t             rem_r [QUO_W];
  area_t             dv_r  [QUO_W];
  logic [QUO_W-1:0]  dq_r  [QUO_W+1];
  logic              sat_r [QUO_W+1];

  // Square root stage registers.
  weight_t                 rt_r  [1:WEIGHT_W];
  logic                    ss_r  [1:WEIGHT_W];
  logic [ROOT_REM_W-1:0]   rm_r  [1:WEIGHT_W-1];
  logic [QUO_W-1:0]        sd_r  [1:WEIGHT_W-1];

  // Entry: the quotient overflows 32 bits exactly when sx >= 16 * sabc.
  always_ff @(posedge clk) begin
    rem_r[0] <= sx >> GUARD_W;
    dq_r[0]  <= {sx[GUARD_W-1:0], {RATIO_SHIFT{1'b0}}};
    dv_r[0]  <= sabc;
    sat_r[0] <= ({GUARD_W'(0), sx} >= {sabc, GUARD_W'(0)});
  end

  // Restoring division, one quotient bit per stage. The low dividend bits
  // shift out of dq while quotient bits shift in.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [AREA_W:0]   sh;
    logic [AREA_W+1:0] df;
    logic              ge;

    assign sh = {rem_r[k], dq_r[k][QUO_W-1]};
    assign df = {1'b0, sh} - {2'b00, dv_r[k]};
    assign ge = !df[AREA_W+1];

    always_ff @(posedge clk) begin
      dq_r[k+1]  <= {dq_r[k][QUO_W-2:0], ge};
      sat_r[k+1] <= sat_r[k];
    end

    if (k < QUO_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge ? df[AREA_W-1:0] : sh[AREA_W-1:0];
        dv_r[k+1]  <= dv_r[k];
      end
    end
  end

  // Restoring integer square root, one root bit per stage.
  for (genvar j = 0; j < WEIGHT_W; j++) begin : g_sqrt
    weight_t                 rt_in;
    logic [ROOT_REM_W-1:0]   rm_in;
    logic [QUO_W-1:0]        sd_in;
    logic                    ss_in;
    logic [ROOT_REM_W+1:0]   rmx;
    logic [ROOT_REM_W+1:0]   trial;
    logic [ROOT_REM_W+1:0]   rdf;
    logic                    ge;

    if (j == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = '0;
      assign sd_in = dq_r[QUO_W];
      assign ss_in = sat_r[QUO_W];
    end else begin : g_next
      assign rt_in = rt_r[j];
      assign rm_in = rm_r[j];
      assign sd_in = sd_r[j];
      assign ss_in = ss_r[j];
    end

    assign rmx   = {rm_in, sd_in[QUO_W-1 -: 2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign ge    = (rmx >= trial);
    assign rdf   = rmx - trial;

    always_ff @(posedge clk) begin
      rt_r[j+1] <= {rt_in[WEIGHT_W-2:0], ge};
      ss_r[j+1] <= ss_in;
    end

    if (j < WEIGHT_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rm_r[j+1] <= ge ? rdf[ROOT_REM_W-1:0] : rmx[ROOT_REM_W-1:0];
        sd_r[j+1] <= sd_in << 2;
      end
    end
  end

  // Saturate to the largest code when the quotient overflowed.
  assign weight = ss_r[WEIGHT_W] ? '1 : rt_r[WEIGHT_W];

endmodule

### rtl/triangle_barycentric_weights.sv
// ============================================================================
// triangle_barycentric_weights: area-ratio barycentric weights of a point
// Squared cross-product areas of ABC, CAP, ABP and BCP, then three exact
// square-root ratio lanes giving saturating Q2.14 weights.
// ============================================================================
// The block takes one item in every clock cycle: busy is never raised, so an
// item is transferred whenever start is high. Each result appears on out_data
// with out_valid high for one cycle, after its transfer passes through seven
// stages that form the squared areas (edge differences, products, cross terms,
// magnitudes, split squares, square assembly, sums), then through each weight
// lane's entry stage, 32 restoring divider stages and 16 square root stages,
// and a final output register. Results leave in transfer order. The
// receiver cannot hold results off, so it must take each result in the one
// cycle that out_valid is high.
// ============================================================================
module triangle_barycentric_weights
  import tbw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tbw_in_t  in_data,
  output logic     out_valid,
  output tbw_out_t out_data
);

  localparam int PIPE_LAT = FRONT_STAGES + RATIO_LAT + 1;

  logic accept;
  coord_t pt [NUM_PT][NUM_AXIS];

  logic signed [DIFF_W-1:0]  u_r  [NUM_TRI][NUM_AXIS];
  logic signed [DIFF_W-1:0]  v_r  [NUM_TRI][NUM_AXIS];
  logic signed [PROD_W-1:0]  pa_r [NUM_TRI][NUM_AXIS];
  logic signed [PROD_W-1:0]  pb_r [NUM_TRI][NUM_AXIS];
  logic signed [CROSS_W-1:0] cr_r [NUM_TRI][NUM_AXIS];
  logic [MAG_W-1:0]          mg_r [NUM_TRI][NUM_AXIS];
  logic [MAG_W-1:0]          hh_r [NUM_TRI][NUM_AXIS];
  logic [MAG_W-1:0]          hl_r [NUM_TRI][NUM_AXIS];
  logic [MAG_W-1:0]          ll_r [NUM_TRI][NUM_AXIS];
  area_t                     sq_r [NUM_TRI][NUM_AXIS];
  area_t                     area_r [NUM_TRI];

  logic     front_vld_r [FRONT_STAGES];
  tbw_ctl_t ctl_r [RATIO_LAT];
  weight_t  wt [NUM_WT];

  logic     out_valid_r;
  tbw_out_t out_data_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input points by index.
  assign pt[PT_A][0] = in_data.a_x;
  assign pt[PT_A][1] = in_data.a_y;
  assign pt[PT_A][2] = in_data.a_z;
  assign pt[PT_B][0] = in_data.b_x;
  assign pt[PT_B][1] = in_data.b_y;
  assign pt[PT_B][2] = in_data.b_z;
  assign pt[PT_C][0] = in_data.c_x;
  assign pt[PT_C][1] = in_data.c_y;
  assign pt[PT_C][2] = in_data.c_z;
  assign pt[PT_P][0] = in_data.p_x;
  assign pt[PT_P][1] = in_data.p_y;
  assign pt[PT_P][2] = in_data.p_z;

  // Squared cross-product length of every triangle, one axis per lane.
  for (genvar t = 0; t < NUM_TRI; t++) begin : g_tri
    for (genvar c = 0; c < NUM_AXIS; c++) begin : g_axis
      localparam int J1 = (c + 1) % NUM_AXIS;
      localparam int J2 = (c + 2) % NUM_AXIS;

      // Edge vectors from the triangle's origin.
      always_ff @(posedge clk) begin
        u_r[t][c] <= DIFF_W'(pt[TRI_P1[t]][c]) - DIFF_W'(pt[TRI_ORG[t]][c]);
        v_r[t][c] <= DIFF_W'(pt[TRI_P2[t]][c]) - DIFF_W'(pt[TRI_ORG[t]][c]);
      end

      // The two products of this cross component.
      always_ff @(posedge clk) begin
        pa_r[t][c] <= u_r[t][J1] * v_r[t][J2];
        pb_r[t][c] <= u_r[t][J2] * v_r[t][J1];
      end

      // Cross component and its magnitude.
      always_ff @(posedge clk) begin
        cr_r[t][c] <= CROSS_W'(pa_r[t][c]) - CROSS_W'(pb_r[t][c]);
        mg_r[t][c] <= MAG_W'(cr_r[t][c] < 0 ? -cr_r[t][c] : cr_r[t][c]);
      end

      // Square split into half-width partial products.
      always_ff @(posedge clk) begin
        hh_r[t][c] <= mg_r[t][c][MAG_W-1:HALF_W] * mg_r[t][c][MAG_W-1:HALF_W];
        hl_r[t][c] <= mg_r[t][c][MAG_W-1:HALF_W] * mg_r[t][c][HALF_W-1:0];
        ll_r[t][c] <= mg_r[t][c][HALF_W-1:0] * mg_r[t][c][HALF_W-1:0];
      end

      // Square assembled; the cross term counts twice.
      always_ff @(posedge clk) begin
        sq_r[t][c] <= {hh_r[t][c], ll_r[t][c]} + (AREA_W'(hl_r[t][c]) << (HALF_W + 1));
      end
    end

    // Sum of the three squared components.
    always_ff @(posedge clk) begin
      area_r[t] <= sq_r[t][0] + sq_r[t][1] + sq_r[t][2];
    end
  end

  // Valid bits of the area stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_STAGES; i++) begin
        front_vld_r[i] <= 1'b0;
      end
    end else begin
      front_vld_r[0] <= accept;
      for (int i = 1; i < FRONT_STAGES; i++) begin
        front_vld_r[i] <= front_vld_r[i-1];
      end
    end
  end

  // Valid and degenerate flag follow the weight lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RATIO_LAT; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0].valid      <= front_vld_r[FRONT_STAGES-1];
      ctl_r[0].degenerate <= (area_r[TRI_ABC] == '0);
      for (int i = 1; i < RATIO_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // One ratio lane per weight: CAP, ABP and BCP against ABC.
  for (genvar w = 0; w < NUM_WT; w++) begin : g_lane
    tbw_ratio u_ratio (
      .clk    (clk),
      .sx     (area_r[w + 1]),
      .sabc   (area_r[TRI_ABC]),
      .weight (wt[w])
    );
  end

  // Output register; a degenerate triangle gives zero weights.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[RATIO_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.degenerate <= ctl_r[RATIO_LAT-1].degenerate;
    out_data_r.weight_u   <= ctl_r[RATIO_LAT-1].degenerate ? '0 : wt[0];
    out_data_r.weight_v   <= ctl_r[RATIO_LAT-1].degenerate ? '0 : wt[1];
    out_data_r.weight_w   <= ctl_r[RATIO_LAT-1].degenerate ? '0 : wt[2];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A transfer yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("transfer produced no result at the expected cycle");

  // No result appears without a transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##PIPE_LAT !out_valid)
    else $error("result without a matching transfer");

  // A degenerate triangle carries zero weights.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.weight_u == '0 && out_data.weight_v == '0 &&
       out_data.weight_w == '0))
    else $error("degenerate result with nonzero weights");

endmodule
